@@ src/grpm_pkg.sv @@
// Shared types and constants for the gapped row position mapper.
package grpm_pkg;

   localparam int POS_W  = 16;
   localparam int OFF_W  = 15;
   localparam int GLEN_W = 15;
   localparam int RES_W  = 8;
   localparam int LEN_W  = 16;
   localparam int UNG_W  = 13;

   localparam logic [RES_W-1:0] GAP_CHAR = 8'd45;
   localparam logic [LEN_W-1:0] LEN_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_GAP     = 2'd1,
      OP_RESIDUE = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    opcode;
      logic signed [POS_W-1:0]   position;
      logic [OFF_W-1:0]          gap_offset;
      logic [GLEN_W-1:0]         gap_length;
      logic [RES_W-1:0]          residue;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_PREP,
      ST_WALK,
      ST_RESIDUE,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic              act;
      logic              gap;
      logic [LEN_W-1:0]  col;
      logic [LEN_W:0]    skip;
   } walker_type;

endpackage

@@ src/grpm_front.sv @@
// Input decode and two-entry command queue of the gapped row position mapper.
module grpm_front import grpm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic signed [POS_W-1:0]  req_position,
   input  logic [GLEN_W-1:0]        req_gap_length,
   input  logic [RES_W-1:0]         req_residue,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output cmd_type                  cmd
);

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;
   cmd_type     decoded;

   always_comb begin
      decoded.opcode     = op_type'(req_opcode);
      decoded.position   = req_position;
      decoded.gap_offset = req_position[POS_W-1] ? '0 : req_position[OFF_W-1:0];
      decoded.gap_length = req_gap_length;
      decoded.residue    = req_residue;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance on push");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count did not drop on pop");
`endif

endmodule

@@ src/grpm_back.sv @@
// Execution side of the gapped row position mapper: row stores, gap walk, result register.
module grpm_back import grpm_pkg::*; #(
   parameter int GAP_DEPTH = 64,
   parameter int SEQ_DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  cmd_type                  cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [RES_W-1:0]         rsp_column_char,
   output logic signed [UNG_W-1:0]  rsp_ungapped_index,
   output logic [LEN_W-1:0]         rsp_row_length,
   output logic [LEN_W-1:0]         rsp_trimmed_length,
   output logic                     rsp_overflow
);

   localparam int GCW = $clog2(GAP_DEPTH + 1);
   localparam int GAW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
   localparam int RCW = $clog2(SEQ_DEPTH + 1);
   localparam int SAW = $clog2(SEQ_DEPTH);
   localparam logic [GCW-1:0] GAP_FULL = GCW'(GAP_DEPTH);
   localparam logic [RCW-1:0] RES_FULL = RCW'(SEQ_DEPTH);
   localparam logic [LEN_W:0] BEFORE_SAT = {1'b1, {LEN_W{1'b0}}};

   function automatic walker_type walk_step(walker_type w, logic [OFF_W-1:0] off,
                                            logic [GLEN_W-1:0] len);
      walker_type       r;
      logic [LEN_W-1:0] end_col;
      logic [LEN_W+1:0] sum;
      r       = w;
      end_col = {1'b0, off} + {1'b0, len};
      sum     = {1'b0, w.skip} + (LEN_W + 2)'(len);
      if (w.act) begin
         if ({1'b0, off} > w.col) begin
            r.act = 1'b0;
         end else if (w.col < end_col) begin
            r.act = 1'b0;
            r.gap = 1'b1;
         end else begin
            r.skip = (sum > (LEN_W + 2)'(BEFORE_SAT)) ? BEFORE_SAT : sum[LEN_W:0];
         end
      end
      return r;
   endfunction

   logic [OFF_W-1:0]  gap_off_mem [GAP_DEPTH];
   logic [GLEN_W-1:0] gap_len_mem [GAP_DEPTH];
   logic [RES_W-1:0]  res_mem     [SEQ_DEPTH];

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [GCW-1:0]    gap_count_ff, gap_count_in;
   logic [RCW-1:0]    res_count_ff, res_count_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [GLEN_W-1:0] last_len_ff, last_len_in;
   logic              ovf_ff, ovf_in;
   logic [GCW-1:0]    walk_idx_ff, walk_idx_in;
   walker_type        q_ff, q_in;
   walker_type        t_ff, t_in;
   logic [UNG_W-1:0]  q_idx_ff, q_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [UNG_W-1:0]  rsp_ung_ff, rsp_ung_in;
   logic [LEN_W-1:0]  rsp_rowlen_ff, rsp_rowlen_in;
   logic [LEN_W-1:0]  rsp_trim_ff, rsp_trim_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [OFF_W-1:0]  gap_off_rd_ff;
   logic [GLEN_W-1:0] gap_len_rd_ff;
   logic [RES_W-1:0]  res_q_rd_ff;
   logic [RES_W-1:0]  res_t_rd_ff;

   logic              gap_we, res_we;
   logic [GAW-1:0]    gap_raddr;
   logic [SAW-1:0]    q_raddr, t_raddr;
   logic [LEN_W:0]    rl_sum;
   logic [LEN_W-1:0]  row_len;
   logic [LEN_W:0]    total_sum;
   logic              q_col_ok;
   walker_type        q_step, t_step;
   logic [LEN_W-1:0]  q_idx, t_idx;
   logic              q_rgap, t_rgap;
   logic [RES_W-1:0]  q_char;
   logic              t_is_gap;
   logic [LEN_W-1:0]  trim_len;

   assign rl_sum    = {1'b0, total_ff} + (LEN_W + 1)'(res_count_ff);
   assign row_len   = rl_sum[LEN_W] ? LEN_MAX : rl_sum[LEN_W-1:0];
   assign total_sum = {1'b0, total_ff} + (LEN_W + 1)'(cmd_ff.gap_length);
   assign q_col_ok  = (cmd_ff.opcode == OP_QUERY) && !cmd_ff.position[POS_W-1]
                      && (LEN_W'(cmd_ff.position) < row_len);

   assign q_step = walk_step(q_ff, gap_off_rd_ff, gap_len_rd_ff);
   assign t_step = walk_step(t_ff, gap_off_rd_ff, gap_len_rd_ff);

   assign q_idx  = q_ff.col - q_ff.skip[LEN_W-1:0];
   assign t_idx  = t_ff.col - t_ff.skip[LEN_W-1:0];
   assign q_rgap = q_ff.gap || (q_ff.skip > {1'b0, q_ff.col})
                   || ({1'b0, q_idx} >= (LEN_W + 1)'(res_count_ff));
   assign t_rgap = t_ff.gap || (t_ff.skip > {1'b0, t_ff.col})
                   || ({1'b0, t_idx} >= (LEN_W + 1)'(res_count_ff));

   assign gap_raddr = walk_idx_in[GAW-1:0];
   assign q_raddr   = q_idx[SAW-1:0];
   assign t_raddr   = t_idx[SAW-1:0];

   assign q_char   = q_ff.gap ? GAP_CHAR : res_q_rd_ff;
   assign t_is_gap = t_ff.gap || (res_t_rd_ff == GAP_CHAR);

   always_comb begin
      if ((gap_count_ff == '0) || !t_is_gap) begin
         trim_len = row_len;
      end else if ({1'b0, last_len_ff} > row_len) begin
         trim_len = '0;
      end else begin
         trim_len = row_len - {1'b0, last_len_ff};
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      gap_count_in  = gap_count_ff;
      res_count_in  = res_count_ff;
      total_in      = total_ff;
      last_len_in   = last_len_ff;
      ovf_in        = ovf_ff;
      walk_idx_in   = walk_idx_ff;
      q_in          = q_ff;
      t_in          = t_ff;
      q_idx_in      = q_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_ung_in    = rsp_ung_ff;
      rsp_rowlen_in = rsp_rowlen_ff;
      rsp_trim_in   = rsp_trim_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      cmd_ready     = 1'b0;
      gap_we        = 1'b0;
      res_we        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ovf_in = 1'b0;
            case (cmd_ff.opcode)
               OP_CLEAR: begin
                  gap_count_in = '0;
                  res_count_in = '0;
                  total_in     = '0;
               end
               OP_GAP: begin
                  if (gap_count_ff == GAP_FULL) begin
                     ovf_in = 1'b1;
                  end else begin
                     gap_we       = 1'b1;
                     gap_count_in = gap_count_ff + 1'b1;
                     total_in     = total_sum[LEN_W] ? LEN_MAX : total_sum[LEN_W-1:0];
                     last_len_in  = cmd_ff.gap_length;
                  end
               end
               OP_RESIDUE: begin
                  if (res_count_ff == RES_FULL) begin
                     ovf_in = 1'b1;
                  end else begin
                     res_we       = 1'b1;
                     res_count_in = res_count_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_PREP;
         end
         ST_PREP: begin
            walk_idx_in = '0;
            q_in.act    = q_col_ok;
            q_in.gap    = !q_col_ok;
            q_in.col    = LEN_W'(cmd_ff.position);
            q_in.skip   = '0;
            t_in.act    = (gap_count_ff != '0) && (row_len != '0);
            t_in.gap    = (row_len == '0);
            t_in.col    = row_len - 1'b1;
            t_in.skip   = '0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            if ((walk_idx_ff < gap_count_ff) && (q_ff.act || t_ff.act)) begin
               q_in        = q_step;
               t_in        = t_step;
               walk_idx_in = walk_idx_ff + 1'b1;
            end else begin
               state_in = ST_RESIDUE;
            end
         end
         ST_RESIDUE: begin
            q_in.gap = q_rgap;
            t_in.gap = t_rgap;
            q_idx_in = q_idx[UNG_W-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = q_char;
               rsp_ung_in    = (q_char != GAP_CHAR) ? q_idx_ff : '1;
               rsp_rowlen_in = row_len;
               rsp_trim_in   = trim_len;
               rsp_ovf_in    = ovf_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gap_count_ff <= '0;
         res_count_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_count_ff <= gap_count_in;
         res_count_ff <= res_count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      last_len_ff   <= last_len_in;
      ovf_ff        <= ovf_in;
      walk_idx_ff   <= walk_idx_in;
      q_ff          <= q_in;
      t_ff          <= t_in;
      q_idx_ff      <= q_idx_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_ung_ff    <= rsp_ung_in;
      rsp_rowlen_ff <= rsp_rowlen_in;
      rsp_trim_ff   <= rsp_trim_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (gap_we) begin
         gap_off_mem[gap_count_ff[GAW-1:0]] <= cmd_ff.gap_offset;
         gap_len_mem[gap_count_ff[GAW-1:0]] <= cmd_ff.gap_length;
      end
      gap_off_rd_ff <= gap_off_mem[gap_raddr];
      gap_len_rd_ff <= gap_len_mem[gap_raddr];
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_count_ff[SAW-1:0]] <= cmd_ff.residue;
      end
      res_q_rd_ff <= res_mem[q_raddr];
      res_t_rd_ff <= res_mem[t_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_char    = rsp_char_ff;
   assign rsp_ungapped_index = rsp_ung_ff;
   assign rsp_row_length     = rsp_rowlen_ff;
   assign rsp_trimmed_length = rsp_trim_ff;
   assign rsp_overflow       = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_gap_count_bound: assert property (@(posedge clock) disable iff (reset)
      gap_count_ff <= GAP_FULL) else $error("gap count beyond table depth");
   a_res_count_bound: assert property (@(posedge clock) disable iff (reset)
      res_count_ff <= RES_FULL) else $error("residue count beyond store depth");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_idx_ff <= gap_count_ff))
      else $error("gap walk ran past the table fill");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");
   a_take_to_update: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> (state_ff == ST_UPDATE))
      else $error("taken command did not enter update");
`endif

endmodule

@@ src/gapped_row_position_mapper.sv @@
// Top level of the gapped row position mapper: command queue feeding the row engine.
// Each command passes the update, prep, gap walk, residue and finish steps in order,
// and the gap walk reads one gap table entry a cycle. The engine takes a new command
// only once the last result is registered; the queue holds up to two meanwhile.
// Reset: synchronous, clears the queue, the row counts, the gap total and the result
// valid; gap and residue store contents are kept and only read below the counts.
module gapped_row_position_mapper import grpm_pkg::*; #(
   parameter int GAP_DEPTH = 64,
   parameter int SEQ_DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic signed [POS_W-1:0]  req_position,
   input  logic [GLEN_W-1:0]        req_gap_length,
   input  logic [RES_W-1:0]         req_residue,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [RES_W-1:0]         rsp_column_char,
   output logic signed [UNG_W-1:0]  rsp_ungapped_index,
   output logic [LEN_W-1:0]         rsp_row_length,
   output logic [LEN_W-1:0]         rsp_trimmed_length,
   output logic                     rsp_overflow
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   grpm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_gap_length (req_gap_length),
      .req_residue    (req_residue),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   grpm_back #(
      .GAP_DEPTH (GAP_DEPTH),
      .SEQ_DEPTH (SEQ_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_ready          (cmd_ready),
      .cmd                (cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column_char    (rsp_column_char),
      .rsp_ungapped_index (rsp_ungapped_index),
      .rsp_row_length     (rsp_row_length),
      .rsp_trimmed_length (rsp_trimmed_length),
      .rsp_overflow       (rsp_overflow)
   );

endmodule
